[src/adsr_pkg.sv]
// Shared constants, types and helper functions of the envelope generator.
package adsr_pkg;

   // Fixed-point format of levels and increments
   localparam int FRACTION_BITS = 24;
   localparam int COUNTER_BITS  = 32;
   localparam int LEVEL_BITS    = FRACTION_BITS + 2;
   localparam int INC_BITS      = FRACTION_BITS + 1;
   localparam int PERCENT_BITS  = 7;
   localparam int SECONDS_BITS  = 24;
   localparam int ELAPSED_BITS  = 32;
   localparam int MODE_BITS     = 3;
   localparam int PHASE_BITS    = 3;

   // Working width of the level arithmetic, wide enough for level minus the largest step
   localparam int WIDE_BITS = FRACTION_BITS + 8;

   // Shared multiplier: unsigned A by signed B, result after the shift
   localparam int MUL_A_BITS = FRACTION_BITS + 8;
   localparam int MUL_B_BITS = FRACTION_BITS + 8;
   localparam int PROD_BITS  = MUL_A_BITS + 1 + MUL_B_BITS;
   localparam int MRES_BITS  = FRACTION_BITS + 6;
   localparam int SP_BITS    = FRACTION_BITS + 1;

   // Sustain point floor((p+1) * ONE / 100) as (p+1) * SP_RECIP >> SP_PRE
   localparam int          SP_PRE      = 14;
   localparam logic [63:0] SP_RECIP    =
      ((64'd1 << (FRACTION_BITS + SP_PRE)) + 64'd99) / 64'd100;
   localparam logic [6:0]  PERCENT_MAX = 7'd100;

   // Sustain leak floor(seconds * ONE / (10 * 2^16)): the factor 2^17 is a shift,
   // the factor 5 a reciprocal multiplication.
   localparam int          LEAK_PRE    = 17;
   localparam int          LEAK_Z_BITS = FRACTION_BITS + 7;
   localparam int          LEAK_M      = FRACTION_BITS + 10;
   localparam logic [63:0] LEAK_RECIP  = ((64'd1 << LEAK_M) + 64'd4) / 64'd5;

   localparam logic signed [WIDE_BITS-1:0] ONE_WIDE = WIDE_BITS'(1) << FRACTION_BITS;
   localparam logic signed [WIDE_BITS-1:0] LEVEL_MAX_WIDE =
      {{(WIDE_BITS - LEVEL_BITS + 1){1'b0}}, {(LEVEL_BITS - 1){1'b1}}};
   localparam logic signed [WIDE_BITS-1:0] LEVEL_MIN_WIDE =
      {{(WIDE_BITS - LEVEL_BITS + 1){1'b1}}, {(LEVEL_BITS - 1){1'b0}}};

   // Configuration port
   localparam int REG_COUNT   = 7;
   localparam int INDEX_BITS  = $clog2(REG_COUNT);
   localparam int ADDR_BITS   = INDEX_BITS + 2;
   localparam int DATA_BITS   = 32;

   localparam logic [INC_BITS-1:0] FLOOR_RESET =
      INC_BITS'(((64'd1 << FRACTION_BITS) * 64'd5 + 64'd50) / 64'd100);
   localparam logic [SECONDS_BITS-1:0] SECONDS_RESET = SECONDS_BITS'(5243);

   typedef enum logic [INDEX_BITS-1:0] {
      REG_ATTACK          = 3'd0,
      REG_DECAY           = 3'd1,
      REG_RELEASE         = 3'd2,
      REG_FORCED          = 3'd3,
      REG_SUSTAIN         = 3'd4,
      REG_FLOOR           = 3'd5,
      REG_RELEASE_SECONDS = 3'd6
   } reg_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_TICK     = 3'd0,
      MODE_NOTE_ON  = 3'd1,
      MODE_NOTE_OFF = 3'd2,
      MODE_REQUEST  = 3'd3,
      MODE_RESTART  = 3'd4
   } mode_type;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4,
      PH_FORCED  = 3'd5,
      PH_OFFREL  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      MS_FRAC   = 2'd0,
      MS_SPOINT = 2'd1,
      MS_LEAK   = 2'd2
   } mul_shift_type;

   typedef struct packed {
      logic [INC_BITS-1:0]     attack_inc;
      logic [INC_BITS-1:0]     decay_inc;
      logic [INC_BITS-1:0]     release_inc;
      logic [INC_BITS-1:0]     forced_inc;
      logic [PERCENT_BITS-1:0] sustain_percent;
      logic [INC_BITS-1:0]     floor_level;
      logic [SECONDS_BITS-1:0] release_seconds;
   } cfg_type;

   typedef struct packed {
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
      mul_shift_type         shift;
   } mul_req_type;

   // Clamp a working value to the signed level range.
   function automatic logic signed [LEVEL_BITS-1:0] sat_level(
      input logic signed [WIDE_BITS-1:0] v);
      logic signed [LEVEL_BITS-1:0] r;
      if (v > LEVEL_MAX_WIDE) begin
         r = LEVEL_MAX_WIDE[LEVEL_BITS-1:0];
      end else if (v < LEVEL_MIN_WIDE) begin
         r = LEVEL_MIN_WIDE[LEVEL_BITS-1:0];
      end else begin
         r = v[LEVEL_BITS-1:0];
      end
      return r;
   endfunction

endpackage

[src/adsr_csr.sv]
// Configuration register file of the envelope generator behind the APB-style port.
module adsr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [adsr_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [adsr_pkg::DATA_BITS-1:0]  pwdata,
   output logic [adsr_pkg::DATA_BITS-1:0]  prdata,
   output logic                            pready,
   output adsr_pkg::cfg_type               cfg
);

   adsr_pkg::cfg_type                     cfg_ff;
   adsr_pkg::cfg_type                     cfg_in;
   logic [adsr_pkg::INDEX_BITS-1:0]       index;
   logic                                  wr_en;

   assign pready = 1'b1;
   assign index  = paddr[adsr_pkg::ADDR_BITS-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            adsr_pkg::REG_ATTACK: begin
               cfg_in.attack_inc = pwdata[adsr_pkg::INC_BITS-1:0];
            end
            adsr_pkg::REG_DECAY: begin
               cfg_in.decay_inc = pwdata[adsr_pkg::INC_BITS-1:0];
            end
            adsr_pkg::REG_RELEASE: begin
               cfg_in.release_inc = pwdata[adsr_pkg::INC_BITS-1:0];
            end
            adsr_pkg::REG_FORCED: begin
               cfg_in.forced_inc = pwdata[adsr_pkg::INC_BITS-1:0];
            end
            adsr_pkg::REG_SUSTAIN: begin
               cfg_in.sustain_percent = pwdata[adsr_pkg::PERCENT_BITS-1:0];
            end
            adsr_pkg::REG_FLOOR: begin
               cfg_in.floor_level = pwdata[adsr_pkg::INC_BITS-1:0];
            end
            adsr_pkg::REG_RELEASE_SECONDS: begin
               cfg_in.release_seconds = pwdata[adsr_pkg::SECONDS_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         adsr_pkg::REG_ATTACK:          prdata = adsr_pkg::DATA_BITS'(cfg_ff.attack_inc);
         adsr_pkg::REG_DECAY:           prdata = adsr_pkg::DATA_BITS'(cfg_ff.decay_inc);
         adsr_pkg::REG_RELEASE:         prdata = adsr_pkg::DATA_BITS'(cfg_ff.release_inc);
         adsr_pkg::REG_FORCED:          prdata = adsr_pkg::DATA_BITS'(cfg_ff.forced_inc);
         adsr_pkg::REG_SUSTAIN:         prdata = adsr_pkg::DATA_BITS'(cfg_ff.sustain_percent);
         adsr_pkg::REG_FLOOR:           prdata = adsr_pkg::DATA_BITS'(cfg_ff.floor_level);
         adsr_pkg::REG_RELEASE_SECONDS: prdata = adsr_pkg::DATA_BITS'(cfg_ff.release_seconds);
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_inc      <= '0;
         cfg_ff.decay_inc       <= '0;
         cfg_ff.release_inc     <= '0;
         cfg_ff.forced_inc      <= '0;
         cfg_ff.sustain_percent <= '0;
         cfg_ff.floor_level     <= adsr_pkg::FLOOR_RESET;
         cfg_ff.release_seconds <= adsr_pkg::SECONDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/adsr_mul.sv]
// Shared multiplier of the envelope generator: registered product and selectable scaling shift.
module adsr_mul (
   input  logic                                 clock,
   input  adsr_pkg::mul_req_type                req,
   output logic signed [adsr_pkg::MRES_BITS-1:0] result
);

   logic signed [adsr_pkg::PROD_BITS-1:0] a_ext;
   logic signed [adsr_pkg::PROD_BITS-1:0] b_ext;
   logic signed [adsr_pkg::PROD_BITS-1:0] prod_in;
   logic signed [adsr_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [adsr_pkg::PROD_BITS-1:0] shifted;
   adsr_pkg::mul_shift_type               shift_in;
   adsr_pkg::mul_shift_type               shift_ff;

   always_comb begin
      a_ext    = adsr_pkg::PROD_BITS'($signed({1'b0, req.a}));
      b_ext    = adsr_pkg::PROD_BITS'($signed(req.b));
      prod_in  = a_ext * b_ext;
      shift_in = req.shift;
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
   end

   // Arithmetic shift gives the floor towards minus infinity.
   always_comb begin
      case (shift_ff)
         adsr_pkg::MS_FRAC:   shifted = prod_ff >>> adsr_pkg::FRACTION_BITS;
         adsr_pkg::MS_SPOINT: shifted = prod_ff >>> adsr_pkg::SP_PRE;
         adsr_pkg::MS_LEAK:   shifted = prod_ff >>> adsr_pkg::LEAK_M;
         default:             shifted = prod_ff >>> adsr_pkg::FRACTION_BITS;
      endcase
      result = shifted[adsr_pkg::MRES_BITS-1:0];
   end

endmodule

[src/adsr_seq.sv]
// Sequencer, envelope state and result register of the envelope generator.
module adsr_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [adsr_pkg::MODE_BITS-1:0]        req_mode,
   input  logic [adsr_pkg::PHASE_BITS-1:0]       req_target_phase,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [adsr_pkg::LEVEL_BITS-1:0] rsp_level,
   output logic [adsr_pkg::PHASE_BITS-1:0]       rsp_phase,
   output logic [adsr_pkg::ELAPSED_BITS-1:0]     rsp_elapsed_ticks,
   output logic                                  rsp_note_held,
   output logic                                  rsp_request_rejected,
   input  adsr_pkg::cfg_type                     cfg,
   output adsr_pkg::mul_req_type                 mul_req,
   input  logic signed [adsr_pkg::MRES_BITS-1:0] mul_result
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SPOINT = 2'd1,
      ST_STEP   = 2'd2,
      ST_APPLY  = 2'd3
   } seq_state_type;

   seq_state_type                            state_ff, state_in;
   logic [adsr_pkg::MODE_BITS-1:0]           mode_ff, mode_in;
   logic [adsr_pkg::PHASE_BITS-1:0]          target_ff, target_in;
   logic [adsr_pkg::SP_BITS-1:0]             sp_ff, sp_in;
   adsr_pkg::phase_type                      phase_ff, phase_in;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   level_ff, level_in;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   fcap_ff, fcap_in;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   ocap_ff, ocap_in;
   logic                                     held_ff, held_in;
   logic [adsr_pkg::COUNTER_BITS-1:0]        count_ff, count_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   rsp_level_ff, rsp_level_in;
   logic [adsr_pkg::PHASE_BITS-1:0]          rsp_phase_ff, rsp_phase_in;
   logic [adsr_pkg::ELAPSED_BITS-1:0]        rsp_elapsed_ff, rsp_elapsed_in;
   logic                                     rsp_held_ff, rsp_held_in;
   logic                                     rsp_rejected_ff, rsp_rejected_in;

   logic                                     apply_fire;
   logic [adsr_pkg::PERCENT_BITS-1:0]        pct_clamped;
   logic [adsr_pkg::PERCENT_BITS-1:0]        pct_plus;
   logic [adsr_pkg::SP_BITS-1:0]             sp_now;
   logic [adsr_pkg::SP_BITS-1:0]             sp_use;
   logic [adsr_pkg::LEAK_Z_BITS-1:0]         leak_z;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   cap_lvl;
   adsr_pkg::mul_req_type                    step_req;

   logic signed [adsr_pkg::WIDE_BITS-1:0]    lv_w, step_w, s_w, fl_w, fl2_w, att_w;
   logic signed [adsr_pkg::WIDE_BITS-1:0]    sum_w, diff_w, dsat_w, sus_w, cap_w, cap10_w;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   dsat;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   tick_level;
   adsr_pkg::phase_type                      tick_phase;
   logic signed [adsr_pkg::LEVEL_BITS-1:0]   tick_ocap;

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_level            = rsp_level_ff;
   assign rsp_phase            = rsp_phase_ff;
   assign rsp_elapsed_ticks    = rsp_elapsed_ff;
   assign rsp_note_held        = rsp_held_ff;
   assign rsp_request_rejected = rsp_rejected_ff;

   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   // Operand preparation for the two multiplier passes.
   always_comb begin
      pct_clamped = (cfg.sustain_percent > adsr_pkg::PERCENT_MAX) ?
                    adsr_pkg::PERCENT_MAX : cfg.sustain_percent;
      pct_plus    = pct_clamped + adsr_pkg::PERCENT_BITS'(1);
      sp_now      = mul_result[adsr_pkg::SP_BITS-1:0];
      sp_use      = (state_ff == ST_STEP) ? sp_now : sp_ff;
      leak_z      = adsr_pkg::LEAK_Z_BITS'(
                       {cfg.release_seconds, {adsr_pkg::FRACTION_BITS{1'b0}}}
                       >> adsr_pkg::LEAK_PRE);
      cap_lvl     = (ocap_ff == '0) ? level_ff : ocap_ff;
   end

   // Step request of the current phase. It is issued again while the item waits
   // in its last step, so that the product still holds the step when it finishes.
   always_comb begin
      step_req.a     = '0;
      step_req.b     = '0;
      step_req.shift = adsr_pkg::MS_FRAC;
      case (phase_ff)
         adsr_pkg::PH_DECAY: begin
            step_req.a = adsr_pkg::MUL_A_BITS'(cfg.decay_inc);
            step_req.b = adsr_pkg::ONE_WIDE - adsr_pkg::MUL_B_BITS'(sp_use);
         end
         adsr_pkg::PH_SUSTAIN: begin
            step_req.a     = adsr_pkg::MUL_A_BITS'(adsr_pkg::LEAK_RECIP);
            step_req.b     = adsr_pkg::MUL_B_BITS'(leak_z);
            step_req.shift = adsr_pkg::MS_LEAK;
         end
         adsr_pkg::PH_RELEASE: begin
            step_req.a = adsr_pkg::MUL_A_BITS'(cfg.release_inc);
            step_req.b = adsr_pkg::MUL_B_BITS'(sp_use);
         end
         adsr_pkg::PH_FORCED: begin
            step_req.a = adsr_pkg::MUL_A_BITS'(cfg.forced_inc);
            step_req.b = adsr_pkg::MUL_B_BITS'(fcap_ff);
         end
         adsr_pkg::PH_OFFREL: begin
            step_req.a = adsr_pkg::MUL_A_BITS'(cfg.release_inc);
            step_req.b = adsr_pkg::MUL_B_BITS'(cap_lvl);
         end
         default: begin
            step_req.a = '0;
         end
      endcase
   end

   // Level rule of one tick; the step of the current phase arrives from the multiplier.
   always_comb begin
      lv_w    = adsr_pkg::WIDE_BITS'(level_ff);
      step_w  = adsr_pkg::WIDE_BITS'(mul_result);
      s_w     = adsr_pkg::WIDE_BITS'(sp_ff);
      fl_w    = adsr_pkg::WIDE_BITS'(cfg.floor_level);
      fl2_w   = fl_w <<< 1;
      att_w   = adsr_pkg::WIDE_BITS'(cfg.attack_inc);
      sum_w   = lv_w + att_w;
      diff_w  = lv_w - step_w;
      dsat    = adsr_pkg::sat_level(diff_w);
      dsat_w  = adsr_pkg::WIDE_BITS'(dsat);
      sus_w   = (lv_w <= fl2_w) ? dsat_w : lv_w;
      cap_w   = adsr_pkg::WIDE_BITS'(cap_lvl);
      cap10_w = (cap_w <<< 3) + (cap_w <<< 1);

      tick_level = level_ff;
      tick_phase = phase_ff;
      tick_ocap  = ocap_ff;
      case (phase_ff)
         adsr_pkg::PH_IDLE: begin
            tick_level = '0;
         end
         adsr_pkg::PH_ATTACK: begin
            if (sum_w >= adsr_pkg::ONE_WIDE) begin
               tick_level = adsr_pkg::ONE_WIDE[adsr_pkg::LEVEL_BITS-1:0];
               tick_phase = adsr_pkg::PH_DECAY;
            end else begin
               tick_level = sum_w[adsr_pkg::LEVEL_BITS-1:0];
            end
         end
         adsr_pkg::PH_DECAY: begin
            tick_level = dsat;
            if (dsat_w - s_w <= fl_w) begin
               tick_phase = adsr_pkg::PH_SUSTAIN;
            end
         end
         adsr_pkg::PH_SUSTAIN: begin
            tick_level = (sus_w <= fl_w) ? '0 : sus_w[adsr_pkg::LEVEL_BITS-1:0];
         end
         adsr_pkg::PH_RELEASE: begin
            if (lv_w <= step_w) begin
               tick_level = '0;
               tick_phase = adsr_pkg::PH_IDLE;
            end else begin
               tick_level = dsat;
            end
         end
         adsr_pkg::PH_FORCED: begin
            if (lv_w <= step_w) begin
               tick_level = '0;
               tick_phase = held_ff ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_IDLE;
            end else begin
               tick_level = dsat;
            end
         end
         adsr_pkg::PH_OFFREL: begin
            if ((lv_w <= step_w) || (cap10_w <= adsr_pkg::ONE_WIDE)) begin
               tick_level = '0;
               tick_ocap  = '0;
               tick_phase = adsr_pkg::PH_IDLE;
            end else begin
               tick_level = dsat;
               tick_ocap  = cap_lvl;
            end
         end
         default: begin
            tick_level = '0;
         end
      endcase
   end

   // Sequencer and next-state selection.
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      target_in       = target_ff;
      sp_in           = sp_ff;
      phase_in        = phase_ff;
      level_in        = level_ff;
      fcap_in         = fcap_ff;
      ocap_in         = ocap_ff;
      held_in         = held_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_level_in    = rsp_level_ff;
      rsp_phase_in    = rsp_phase_ff;
      rsp_elapsed_in  = rsp_elapsed_ff;
      rsp_held_in     = rsp_held_ff;
      rsp_rejected_in = rsp_rejected_ff;
      mul_req.a       = '0;
      mul_req.b       = '0;
      mul_req.shift   = adsr_pkg::MS_FRAC;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               target_in = req_target_phase;
               state_in  = ST_SPOINT;
            end
         end
         ST_SPOINT: begin
            mul_req.a     = adsr_pkg::MUL_A_BITS'(adsr_pkg::SP_RECIP);
            mul_req.b     = adsr_pkg::MUL_B_BITS'(pct_plus);
            mul_req.shift = adsr_pkg::MS_SPOINT;
            state_in      = ST_STEP;
         end
         ST_STEP: begin
            sp_in    = sp_now;
            mul_req  = step_req;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            mul_req = step_req;
            if (apply_fire) begin
               rsp_rejected_in = 1'b0;
               case (mode_ff)
                  adsr_pkg::MODE_TICK: begin
                     level_in = tick_level;
                     phase_in = tick_phase;
                     ocap_in  = tick_ocap;
                     if (held_ff) begin
                        count_in = count_ff + adsr_pkg::COUNTER_BITS'(1);
                     end
                  end
                  adsr_pkg::MODE_NOTE_ON: begin
                     held_in  = 1'b1;
                     count_in = '0;
                  end
                  adsr_pkg::MODE_NOTE_OFF: begin
                     held_in = 1'b0;
                  end
                  adsr_pkg::MODE_REQUEST: begin
                     if (target_ff > adsr_pkg::PHASE_BITS'(adsr_pkg::PH_OFFREL)) begin
                        rsp_rejected_in = 1'b1;
                     end else if ((target_ff == adsr_pkg::PHASE_BITS'(adsr_pkg::PH_RELEASE))
                                  && (phase_ff != adsr_pkg::PH_SUSTAIN)) begin
                        phase_in = adsr_pkg::PH_FORCED;
                        fcap_in  = level_ff;
                     end else begin
                        phase_in = adsr_pkg::phase_type'(target_ff);
                        if (target_ff == adsr_pkg::PHASE_BITS'(adsr_pkg::PH_FORCED)) begin
                           fcap_in = level_ff;
                        end
                     end
                  end
                  adsr_pkg::MODE_RESTART: begin
                     phase_in = adsr_pkg::PH_ATTACK;
                     level_in = '0;
                     fcap_in  = adsr_pkg::LEVEL_BITS'(cfg.floor_level);
                  end
                  default: begin
                     level_in = level_ff;
                  end
               endcase
               rsp_valid_in   = 1'b1;
               rsp_level_in   = level_in;
               rsp_phase_in   = adsr_pkg::PHASE_BITS'(phase_in);
               rsp_elapsed_in = adsr_pkg::ELAPSED_BITS'(count_in);
               rsp_held_in    = held_in;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= adsr_pkg::PH_IDLE;
         level_ff     <= '0;
         fcap_ff      <= '0;
         ocap_ff      <= '0;
         held_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         fcap_ff      <= fcap_in;
         ocap_ff      <= ocap_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff         <= mode_in;
      target_ff       <= target_in;
      sp_ff           <= sp_in;
      rsp_level_ff    <= rsp_level_in;
      rsp_phase_ff    <= rsp_phase_in;
      rsp_elapsed_ff  <= rsp_elapsed_in;
      rsp_held_ff     <= rsp_held_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

   a_apply_loads_result: assert property (@(posedge clock) disable iff (reset)
      apply_fire |=> rsp_valid_ff && (rsp_level_ff == level_ff))
      else $error("finished item did not reach the result register");

   a_note_on_clears: assert property (@(posedge clock) disable iff (reset)
      apply_fire && (mode_ff == adsr_pkg::MODE_NOTE_ON) |=> held_ff && (count_ff == '0))
      else $error("note on did not set the held flag and clear the counter");

   a_restart_attack: assert property (@(posedge clock) disable iff (reset)
      apply_fire && (mode_ff == adsr_pkg::MODE_RESTART)
      |=> (phase_ff == adsr_pkg::PH_ATTACK) && (level_ff == '0))
      else $error("restart did not enter attack at level zero");

   a_reject_only_request: assert property (@(posedge clock) disable iff (reset)
      apply_fire && (mode_ff != adsr_pkg::MODE_REQUEST) |=> !rsp_rejected_ff)
      else $error("rejection flagged for an item that is not a phase request");

endmodule

[src/adsr_envelope_generator.sv]
// Top level of the seven-phase envelope generator.
//
// Each item on the request channel is a tick, a note on, a note off, a phase
// request or a restart, and every item produces exactly one result: the
// envelope level (signed, 24 fraction bits), the phase, the elapsed-tick count,
// the held flag and a flag for a rejected phase request. An item is accepted,
// then makes two passes through a single shared multiplier (the first forms
// the sustain point from the sustain percentage, the second forms the step
// of the current phase), then updates the envelope state and loads the
// result register before the next item can be accepted.
// The request side is not ready while an item is being worked on.
// A finished result waits in its own register, so the next item may be
// accepted while the previous result has not yet been taken; if the previous
// result is still unread when the next item finishes, that item holds in its
// last step until the result register frees. Configuration registers sit on an
// APB-style port (one register every four bytes) and are to be written only
// while no item is in flight.
module adsr_envelope_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [adsr_pkg::MODE_BITS-1:0]        req_mode,
   input  logic [adsr_pkg::PHASE_BITS-1:0]       req_target_phase,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [adsr_pkg::LEVEL_BITS-1:0] rsp_level,
   output logic [adsr_pkg::PHASE_BITS-1:0]       rsp_phase,
   output logic [adsr_pkg::ELAPSED_BITS-1:0]     rsp_elapsed_ticks,
   output logic                                  rsp_note_held,
   output logic                                  rsp_request_rejected,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [adsr_pkg::ADDR_BITS-1:0]        paddr,
   input  logic [adsr_pkg::DATA_BITS-1:0]        pwdata,
   output logic [adsr_pkg::DATA_BITS-1:0]        prdata,
   output logic                                  pready
);

   // Current register contents, seen by the sequencer at all times.
   adsr_pkg::cfg_type                     cfg;

   // Operand request to the multiplier and its registered, scaled result.
   adsr_pkg::mul_req_type                 mul_req;
   logic signed [adsr_pkg::MRES_BITS-1:0] mul_result;

   adsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The one multiplier of the block. Its product is registered, so a request
   // issued in one cycle is read back by the sequencer in the next.
   adsr_mul u_mul (
      .clock  (clock),
      .req    (mul_req),
      .result (mul_result)
   );

   // The sequencer owns the envelope state, steps each item through the
   // multiplier twice and drives the result register.
   adsr_seq u_seq (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_target_phase     (req_target_phase),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_level            (rsp_level),
      .rsp_phase            (rsp_phase),
      .rsp_elapsed_ticks    (rsp_elapsed_ticks),
      .rsp_note_held        (rsp_note_held),
      .rsp_request_rejected (rsp_request_rejected),
      .cfg                  (cfg),
      .mul_req              (mul_req),
      .mul_result           (mul_result)
   );

endmodule
